// ----- rtl/core/next_fit_heap_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the heap allocator checker.
// ---------------------------------------------------------------------------
`ifndef NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NFHA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("heap allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NFHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("heap allocator check failed");

`endif

// ----- rtl/core/nfha_pkg.sv -----
// ---------------------------------------------------------------------------
// nfha_pkg
// Shared constants of the next-fit heap allocator.
// ---------------------------------------------------------------------------
package nfha_pkg;

	localparam int DEF_HEAP_BYTES = 4096;

	localparam int CMD_W  = 2;
	localparam int SIZE_W = 13;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADINIT = 2'd3;

endpackage

// ----- rtl/core/nfha_ram.sv -----
// ---------------------------------------------------------------------------
// nfha_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module nfha_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/next_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// next_fit_heap_allocator
// Boundary-tag heap manager with next-fit allocation and immediate coalescing.
// ---------------------------------------------------------------------------
// Steps: init writes first header, last footer and end mark in turn; rejects
//   go straight to the result; free walks blocks from the first header to
//   the target, then coalesces; alloc visits headers from the rover and wraps
//   at the end mark; the single tag RAM port (one read per step) sets the pace.
// Throughput: one transaction at a time; the next is taken once the result
//   is registered, while that result may still wait at the output.
// Reset: arst_n clears the sequencer, the ready flag and the output valid;
//   tag RAM contents are undefined until init writes them.
// ---------------------------------------------------------------------------
module next_fit_heap_allocator
	import nfha_pkg::*;
#(
	parameter int HEAP_BYTES = nfha_pkg::DEF_HEAP_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nfha_pkg::CMD_W-1:0]    command,
	input  logic [nfha_pkg::SIZE_W-1:0]   request_size,
	input  logic [nfha_pkg::SIZE_W-1:0]   block_offset,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nfha_pkg::STAT_W-1:0]   status,
	output logic [nfha_pkg::SIZE_W-1:0]   payload_offset
);

	// Region geometry, all in bytes. Tags are one per 4-byte word.
	localparam int REGION = (HEAP_BYTES / 8) * 8;
	localparam int DEPTH  = REGION / 4;
	localparam int AW     = $clog2(DEPTH);
	localparam int LB     = $clog2(REGION) + 1;
	localparam int TW     = (LB > SIZE_W) ? LB : SIZE_W;  // tag width
	localparam int CW     = TW + 1;                       // byte offset math width
	localparam int WALK   = REGION / 8 + 4;               // walk step bound
	localparam int IW     = $clog2(WALK + 1);

	localparam logic [CW-1:0] FIRST_HDR = CW'(4);
	localparam logic [CW-1:0] END_MARK  = CW'(REGION - 4);
	localparam logic [CW-1:0] LAST_FTR  = CW'(REGION - 8);
	localparam logic [CW-1:0] SPAN      = CW'(REGION - 8);
	localparam logic [IW-1:0] WALK_MAX  = IW'(WALK);

	// Sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_INIT0 = 5'd1;
	localparam logic [4:0] S_INIT1 = 5'd2;
	localparam logic [4:0] S_INIT2 = 5'd3;
	localparam logic [4:0] S_AWALK = 5'd4;
	localparam logic [4:0] S_AHDR  = 5'd5;
	localparam logic [4:0] S_AW1   = 5'd6;
	localparam logic [4:0] S_AW2   = 5'd7;
	localparam logic [4:0] S_AW3   = 5'd8;
	localparam logic [4:0] S_AWN   = 5'd9;
	localparam logic [4:0] S_FWALK = 5'd10;
	localparam logic [4:0] S_FSZ   = 5'd11;
	localparam logic [4:0] S_FH    = 5'd12;
	localparam logic [4:0] S_FN    = 5'd13;
	localparam logic [4:0] S_FPC   = 5'd14;
	localparam logic [4:0] S_FP    = 5'd15;
	localparam logic [4:0] S_FS    = 5'd16;
	localparam logic [4:0] S_FWH   = 5'd17;
	localparam logic [4:0] S_FWF   = 5'd18;
	localparam logic [4:0] S_FWA   = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	logic [4:0]        state_q;
	logic              ready_q;      // heap initialized
	logic [CW-1:0]     rover_q;      // payload offset where next search starts
	logic [CW-1:0]     cur_q;        // header byte offset under inspection
	logic [CW-1:0]     walked_q;
	logic [CW-1:0]     need_q;
	logic [CW-1:0]     sz_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     total_q;
	logic [SIZE_W-1:0] off_q;
	logic [IW-1:0]     i_q;
	logic [TW-1:0]     h_q;          // header of the block being freed/allocated
	logic              pflag_q;      // prev-allocated bit for the merged header
	logic [STAT_W-1:0] fin_status_q;
	logic [SIZE_W-1:0] fin_pay_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SIZE_W-1:0] out_pay_q;

	// tag RAM port
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [TW-1:0]     mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [TW-1:0]     mem_rdata;

	// decoded read data: size field and flags
	logic [CW-1:0]     rsz;
	logic              r_alloc;
	logic              r_prev;
	logic [CW-1:0]     after;
	logic [CW-1:0]     req_ext;
	logic [CW-1:0]     off_ext;

	assign rsz     = {1'b0, mem_rdata[TW-1:3], 3'b000};
	assign r_alloc = mem_rdata[0];
	assign r_prev  = mem_rdata[1];
	assign after   = start_q + total_q;
	assign req_ext = CW'(request_size);
	assign off_ext = CW'(off_q);

	nfha_ram #(
		.WIDTH (TW),
		.DEPTH (DEPTH)
	) u_tags (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Memory port control. Every read issued here is consumed by the
	// following state; writes never target a word that is read in the same
	// cycle, so the RAM needs no bypass.
	always_comb begin
		logic [CW-1:0] waddr_b;
		logic [CW-1:0] raddr_b;
		logic [CW-1:0] wdata_b;

		mem_we  = 1'b0;
		mem_re  = 1'b0;
		waddr_b = cur_q;
		raddr_b = cur_q;
		wdata_b = '0;
		case (state_q)
			S_INIT0: begin
				mem_we  = 1'b1;
				waddr_b = FIRST_HDR;
				wdata_b = SPAN | CW'(2);
			end
			S_INIT1: begin
				mem_we  = 1'b1;
				waddr_b = LAST_FTR;
				wdata_b = SPAN;
			end
			S_INIT2: begin
				mem_we  = 1'b1;
				waddr_b = END_MARK;
				wdata_b = CW'(1);
			end
			S_AWALK, S_FWALK: begin
				mem_re = (i_q != WALK_MAX) && (cur_q < END_MARK);
			end
			S_AW1: begin
				// allocated header keeps the previous-allocated bit
				mem_we  = 1'b1;
				wdata_b = need_q | CW'(1) | CW'({h_q[1], 1'b0});
				raddr_b = cur_q + sz_q;
				mem_re  = (sz_q == need_q) && (cur_q + sz_q < END_MARK);
			end
			S_AW2: begin
				// split remainder header, previous is now allocated
				mem_we  = 1'b1;
				waddr_b = cur_q + need_q;
				wdata_b = (sz_q - need_q) | CW'(2);
			end
			S_AW3: begin
				// split remainder footer at block end minus 4
				mem_we  = 1'b1;
				waddr_b = cur_q + sz_q - CW'(4);
				wdata_b = sz_q - need_q;
			end
			S_AWN: begin
				mem_we  = 1'b1;
				waddr_b = cur_q + sz_q;
				wdata_b = CW'(mem_rdata) | CW'(2);
			end
			S_FH: begin
				raddr_b = cur_q + rsz;
				mem_re  = r_alloc && (cur_q + rsz < END_MARK);
			end
			S_FPC: begin
				raddr_b = cur_q - CW'(4);
				mem_re  = !h_q[1] && (cur_q > FIRST_HDR);
			end
			S_FP: begin
				raddr_b = cur_q - rsz;
				mem_re  = (rsz != '0) && (rsz <= cur_q - FIRST_HDR);
			end
			S_FWH: begin
				mem_we  = 1'b1;
				waddr_b = start_q;
				wdata_b = total_q | CW'({pflag_q, 1'b0});
			end
			S_FWF: begin
				mem_we  = 1'b1;
				waddr_b = after - CW'(4);
				wdata_b = total_q;
				raddr_b = after;
				mem_re  = after < END_MARK;
			end
			S_FWA: begin
				mem_we  = 1'b1;
				waddr_b = after;
				wdata_b = CW'(mem_rdata) & ~CW'(2);
			end
			default: begin
			end
		endcase
		mem_waddr = waddr_b[AW+1:2];
		mem_raddr = raddr_b[AW+1:2];
		mem_wdata = wdata_b[TW-1:0];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ready_q      <= 1'b0;
			rover_q      <= FIRST_HDR + CW'(4);
			out_valid_q  <= 1'b0;
		end else begin
			// output register: loaded from DONE, dropped once taken
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fin_pay_q <= '0;
						state_q   <= S_DONE;
						if (command == CMD_INIT) begin
							if (ready_q) begin
								fin_status_q <= ST_BADINIT;
							end else begin
								state_q <= S_INIT0;
							end
						end else if (command == CMD_NONE) begin
							fin_status_q <= ST_REJECT;
						end else if (!ready_q) begin
							fin_status_q <= ST_BADINIT;
						end else if (command == CMD_ALLOC) begin
							if (request_size == '0 || req_ext > SPAN) begin
								fin_status_q <= ST_REJECT;
							end else begin
								// header plus payload, rounded up to 8
								need_q   <= (req_ext + CW'(11)) & ~CW'(7);
								cur_q    <= rover_q - CW'(4);
								i_q      <= '0;
								walked_q <= '0;
								state_q  <= S_AWALK;
							end
						end else begin
							if (block_offset == '0 || block_offset[2:0] != 3'b000) begin
								fin_status_q <= ST_REJECT;
							end else begin
								off_q   <= block_offset;
								cur_q   <= FIRST_HDR;
								i_q     <= '0;
								state_q <= S_FWALK;
							end
						end
					end
				end
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_INIT2;
				S_INIT2: begin
					ready_q      <= 1'b1;
					rover_q      <= FIRST_HDR + CW'(4);
					fin_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				// ---- allocate: next-fit walk from the rover ----
				S_AWALK: begin
					if (i_q == WALK_MAX || cur_q > END_MARK) begin
						fin_status_q <= ST_NOFIT;
						state_q      <= S_DONE;
					end else if (cur_q == END_MARK) begin
						cur_q <= FIRST_HDR;  // wrap at the end mark
						i_q   <= i_q + IW'(1);
					end else begin
						state_q <= S_AHDR;
					end
				end
				S_AHDR: begin
					h_q <= mem_rdata;
					if (!r_alloc && rsz >= need_q) begin
						sz_q    <= rsz;
						state_q <= S_AW1;
					end else if (rsz == '0 || walked_q + rsz >= SPAN) begin
						fin_status_q <= ST_NOFIT;
						state_q      <= S_DONE;
					end else begin
						cur_q    <= cur_q + rsz;
						walked_q <= walked_q + rsz;
						i_q      <= i_q + IW'(1);
						state_q  <= S_AWALK;
					end
				end
				S_AW1: begin
					rover_q      <= cur_q + CW'(4);
					fin_status_q <= ST_OK;
					fin_pay_q    <= SIZE_W'(cur_q + CW'(4));
					if (sz_q != need_q) begin
						state_q <= S_AW2;
					end else if (cur_q + sz_q < END_MARK) begin
						state_q <= S_AWN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_AW2: state_q <= S_AW3;
				S_AW3: state_q <= S_DONE;
				S_AWN: state_q <= S_DONE;
				// ---- free: locate block from the first header ----
				S_FWALK: begin
					if (i_q == WALK_MAX || cur_q >= END_MARK) begin
						fin_status_q <= ST_REJECT;
						state_q      <= S_DONE;
					end else if (cur_q + CW'(4) == off_ext) begin
						state_q <= S_FH;
					end else begin
						state_q <= S_FSZ;
					end
				end
				S_FSZ: begin
					if (rsz == '0) begin
						fin_status_q <= ST_REJECT;
						state_q      <= S_DONE;
					end else begin
						cur_q   <= cur_q + rsz;
						i_q     <= i_q + IW'(1);
						state_q <= S_FWALK;
					end
				end
				S_FH: begin
					h_q     <= mem_rdata;
					sz_q    <= rsz;
					total_q <= rsz;
					start_q <= cur_q;
					pflag_q <= r_prev;
					if (!r_alloc) begin
						fin_status_q <= ST_REJECT;  // double free
						state_q      <= S_DONE;
					end else if (cur_q + rsz < END_MARK) begin
						state_q <= S_FN;
					end else begin
						state_q <= S_FPC;
					end
				end
				S_FN: begin
					if (!r_alloc) begin
						total_q <= total_q + rsz;  // merge with next
					end
					state_q <= S_FPC;
				end
				S_FPC: begin
					if (!h_q[1] && cur_q > FIRST_HDR) begin
						state_q <= S_FP;
					end else begin
						state_q <= S_FWH;
					end
				end
				S_FP: begin
					// previous footer; merge only if it is sane
					if (rsz != '0 && rsz <= cur_q - FIRST_HDR) begin
						start_q <= cur_q - rsz;
						total_q <= total_q + rsz;
						state_q <= S_FS;
					end else begin
						state_q <= S_FWH;
					end
				end
				S_FS: begin
					pflag_q <= r_prev;
					state_q <= S_FWH;
				end
				S_FWH: state_q <= S_FWF;
				S_FWF: begin
					if (start_q != cur_q || (rover_q > start_q && rover_q < after)) begin
						rover_q <= start_q + CW'(4);
					end
					fin_status_q <= ST_OK;
					if (after < END_MARK) begin
						state_q <= S_FWA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FWA: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_status_q <= fin_status_q;
						out_pay_q    <= (fin_status_q == ST_OK) ? fin_pay_q : '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign payload_offset = out_pay_q;

endmodule

// ----- rtl/core/nfha_checker.sv -----
// ---------------------------------------------------------------------------
// nfha_checker
// Port-level checks of the heap allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "next_fit_heap_allocator_macros.svh"

module nfha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [12:0] payload_offset
);

	import nfha_pkg::*;

	`NFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`NFHA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(payload_offset))
	`NFHA_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK, payload_offset == 13'd0)
	`NFHA_ASSERT_NOW(a_pay_align, out_valid && status == ST_OK, payload_offset[2:0] == 3'd0)
	`NFHA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind next_fit_heap_allocator nfha_checker u_nfha_checker (.*);
